// File: rtl/bcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

   // Request kinds carried on the request tuser.
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Action codes.
   localparam logic [3:0] ACT_NONE  = 4'd0;
   localparam logic [3:0] ACT_CLICK = 4'd1;
   localparam logic [3:0] ACT_LONG  = 4'd8;

   // Largest click count that can ever be reported.
   localparam logic [3:0] CLICK_LIMIT = 4'd7;

   // Phase codes of the click state machine.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_PRESS  = 2'd1;
   localparam logic [1:0] PH_WINDOW = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_LONG_PRESS   = 3'd0;
   localparam logic [2:0] REG_CLICK_WINDOW = 3'd1;
   localparam logic [2:0] REG_MAX_CLICKS   = 3'd2;
   localparam logic [2:0] REG_MULTI_ENABLE = 3'd3;
   localparam logic [2:0] REG_DEBOUNCE     = 3'd4;

   // Configuration as seen by the classifier core.
   typedef struct packed {
      logic [15:0] long_press_ticks;
      logic [15:0] click_window_ticks;
      logic [2:0]  max_clicks;
      logic        multi_click_enable;
      logic [7:0]  debounce_ticks;
   } cfg_type;

endpackage
`default_nettype wire

// File: rtl/bcc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier configuration registers
// Holds the five configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bcc_csr
   import bcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LONG_PRESS:   cfg_in.long_press_ticks   = csr_wdata;
            REG_CLICK_WINDOW: cfg_in.click_window_ticks = csr_wdata;
            REG_MAX_CLICKS:   cfg_in.max_clicks         = csr_wdata[2:0];
            REG_MULTI_ENABLE: cfg_in.multi_click_enable = csr_wdata[0];
            REG_DEBOUNCE:     cfg_in.debounce_ticks     = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= 16'd1000;
         cfg_ff.click_window_ticks <= 16'd0;
         cfg_ff.max_clicks         <= 3'd1;
         cfg_ff.multi_click_enable <= 1'b0;
         cfg_ff.debounce_ticks     <= 8'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: rtl/bcc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier core
// Debounce sampler, elapsed counters and the click state machine.
// ----------------------------------------------------------------------------
module bcc_core
   import bcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       tick_en,
   input  wire logic       pin,
   input  wire logic       read_en,
   output logic [3:0]      pending_action
);

   logic [1:0]  phase_ff, phase_in;
   logic        sampled_ff, sampled_in;
   logic        previous_ff, previous_in;
   logic [7:0]  deb_ff, deb_in;
   logic [15:0] press_ff, press_in;
   logic [15:0] release_ff, release_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  action_ff, action_in;

   logic [7:0]  deb_inc;
   logic [15:0] press_inc;
   logic [15:0] release_inc;
   logic [3:0]  count_inc;
   logic        level;
   logic        pressed_now;
   logic        released_now;
   logic [3:0]  max_ext;

   // Saturating increments of the elapsed counters.
   assign deb_inc     = (deb_ff == 8'hFF) ? deb_ff : deb_ff + 8'd1;
   assign press_inc   = (press_ff == 16'hFFFF) ? press_ff : press_ff + 16'd1;
   assign release_inc = (release_ff == 16'hFFFF) ? release_ff : release_ff + 16'd1;
   assign count_inc   = count_ff + 4'd1;
   assign max_ext     = {1'b0, cfg.max_clicks};

   // The pin is sampled once the debounce period has run out.
   assign level        = (deb_inc >= cfg.debounce_ticks) ? pin : sampled_ff;
   assign pressed_now  = !level && previous_ff;
   assign released_now = level && !previous_ff;

   // Next state for one tick or one read.
   always_comb begin
      phase_in    = phase_ff;
      sampled_in  = sampled_ff;
      previous_in = previous_ff;
      deb_in      = deb_ff;
      press_in    = press_ff;
      release_in  = release_ff;
      count_in    = count_ff;
      action_in   = action_ff;

      if (read_en) begin
         action_in = ACT_NONE;
      end else if (tick_en) begin
         deb_in      = (deb_inc >= cfg.debounce_ticks) ? 8'd0 : deb_inc;
         sampled_in  = level;
         previous_in = level;
         press_in    = press_inc;
         release_in  = release_inc;

         unique case (phase_ff)
            PH_PRESS: begin
               if (released_now) begin
                  if (press_inc < cfg.long_press_ticks) begin
                     if (cfg.multi_click_enable) begin
                        count_in   = count_inc;
                        release_in = 16'd0;
                        if (count_inc > max_ext) begin
                           action_in = ACT_NONE;
                           count_in  = 4'd0;
                           phase_in  = PH_IDLE;
                        end else begin
                           phase_in = PH_WINDOW;
                        end
                     end else begin
                        action_in = ACT_CLICK;
                        phase_in  = PH_IDLE;
                        press_in  = 16'd0;
                     end
                  end else begin
                     action_in = ACT_LONG;
                     phase_in  = PH_IDLE;
                  end
               end else if (!level && press_inc >= cfg.long_press_ticks) begin
                  // Long press reported while the button is still held.
                  action_in = ACT_LONG;
                  phase_in  = PH_IDLE;
                  press_in  = 16'd0;
               end
            end
            PH_WINDOW: begin
               if (pressed_now) begin
                  press_in = 16'd0;
                  phase_in = PH_PRESS;
               end else if (release_inc > cfg.click_window_ticks) begin
                  action_in = (count_ff <= max_ext && count_ff <= CLICK_LIMIT) ?
                              count_ff : ACT_NONE;
                  count_in  = 4'd0;
                  phase_in  = PH_IDLE;
               end
            end
            default: begin
               // Idle, and the unused code, which behaves as idle.
               if (pressed_now) begin
                  press_in = 16'd0;
                  phase_in = PH_PRESS;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         sampled_ff  <= 1'b1;
         previous_ff <= 1'b0;
         deb_ff      <= 8'd0;
         press_ff    <= 16'd0;
         release_ff  <= 16'd0;
         count_ff    <= 4'd0;
         action_ff   <= ACT_NONE;
      end else begin
         phase_ff    <= phase_in;
         sampled_ff  <= sampled_in;
         previous_ff <= previous_in;
         deb_ff      <= deb_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         count_ff    <= count_in;
         action_ff   <= action_in;
      end
   end

   assign pending_action = action_ff;

endmodule
`default_nettype wire

// File: rtl/button_click_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button click classifier
// Classifies presses of an active-low button into clicks, click counts and
// long presses, and returns the pending action on a read request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the request side is not
// stalled. A request is captured in an input register and applied to the
// classifier state from there; a read passes its action from the input
// register into the response register, from which the sink takes it. The
// request side stalls only while a read waits in the input register and the
// response register holds an action that the sink has not yet taken.
// Configuration must be written while no request is in flight.
module button_click_classifier
   import bcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] pin_level, [7:1] zero
   input  wire logic [0:0]  req_tuser,   // [0] func
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [3:0] action, [7:4] zero
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff, in_func_in;
   logic       in_pin_ff, in_pin_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_action_ff, out_action_in;
   logic       out_free;
   logic       consume;
   logic       req_take;
   logic [3:0] pending_action;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .tick_en        (consume && (in_func_ff == FUNC_TICK)),
      .pin            (in_pin_ff),
      .read_en        (consume && (in_func_ff == FUNC_READ)),
      .pending_action (pending_action)
   );

   // A read leaves the input register only when the response register is free.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign consume    = in_valid_ff && ((in_func_ff == FUNC_TICK) || out_free);
   assign req_tready = !in_valid_ff || consume;
   assign req_take   = req_tvalid && req_tready;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_pin_in   = in_pin_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_func_in  = req_tuser[0];
         in_pin_in   = req_tdata[0];
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   // Response register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_action_in = out_action_ff;
      if (consume && (in_func_ff == FUNC_READ)) begin
         out_valid_in  = 1'b1;
         out_action_in = pending_action;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_func_ff    <= in_func_in;
      in_pin_ff     <= in_pin_in;
      out_action_ff <= out_action_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_action_ff};

endmodule
`default_nettype wire
